### design/spi_master_register_bridge_assert.svh
// Assertion macros used by the SPI master register bridge datapath.
`ifndef SPI_MASTER_REGISTER_BRIDGE_ASSERT_SVH
`define SPI_MASTER_REGISTER_BRIDGE_ASSERT_SVH

`define SMRB_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("smrb invariant violated");

`define SMRB_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smrb same-cycle check failed");

`define SMRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smrb next-cycle check failed");

`endif

### design/smrb_pkg.sv
// Package with widths, codes, register masks and control structs of the bridge.
package smrb_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int CMD_W  = 2;
  localparam int REG_W  = 3;
  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MISO  = 2'd2;

  localparam logic [REG_W-1:0] REG_CONTROL = 3'd0;
  localparam logic [REG_W-1:0] REG_FIFO    = 3'd1;
  localparam logic [REG_W-1:0] REG_CLOCK   = 3'd2;
  localparam logic [REG_W-1:0] REG_LENGTH  = 3'd3;

  localparam logic [WORD_W-1:0] CLEAR_MASK  = 32'h0000_0030;
  localparam logic [WORD_W-1:0] STAT_ACTIVE = 32'h0000_0080;
  localparam logic [WORD_W-1:0] STAT_DONE   = 32'h0001_0000;
  localparam logic [WORD_W-1:0] STAT_RXD    = 32'h0002_0000;
  localparam logic [WORD_W-1:0] STAT_TXD    = 32'h0004_0000;
  localparam logic [WORD_W-1:0] EMPTY_READ  = 32'h0000_00ff;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_TX   = 1'b1;

  typedef struct packed {
    logic accept;
    logic exec;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic starts;
    logic out_free;
    logic tx_last;
  } dp_status_t;

endpackage

### design/smrb_if.sv
// Request and response channel interfaces of the bridge.
interface smrb_req_if;
  logic                           valid;
  logic                           ready;
  logic [smrb_pkg::CMD_W-1:0]     command;
  logic [smrb_pkg::REG_W-1:0]     reg_index;
  logic [smrb_pkg::WORD_W-1:0]    write_data;
  logic [smrb_pkg::BYTE_W-1:0]    miso_byte;
  logic                           miso_first;

  modport source (output valid, command, reg_index, write_data, miso_byte, miso_first,
                  input ready);
  modport sink (input valid, command, reg_index, write_data, miso_byte, miso_first,
                output ready);
endinterface

interface smrb_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [smrb_pkg::WORD_W-1:0]    read_data;
  logic [smrb_pkg::BYTE_W-1:0]    tx_byte;
  logic                           last;

  modport source (output valid, kind, read_data, tx_byte, last, input ready);
  modport sink (input valid, kind, read_data, tx_byte, last, output ready);
endinterface

### design/smrb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module smrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/smrb_ctrl.sv
// Controller state machine that sequences accept, execute and TX drain.
module smrb_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output smrb_pkg::ctrl_cmd_t    cmd,
  input  smrb_pkg::dp_status_t   sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.accept = in_valid && in_ready;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_read) begin
          if (sts.out_free) begin
            cmd.exec   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.exec   = 1'b1;
          state_next = sts.starts ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.tx_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/smrb_datapath.sv
// Datapath with the word registers, FIFO memories, counters and output register.
`include "spi_master_register_bridge_assert.svh"

module smrb_datapath #(
  parameter int FIFO_DEPTH = smrb_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  smrb_pkg::ctrl_cmd_t           cmd,
  output smrb_pkg::dp_status_t          sts,
  input  logic [smrb_pkg::CMD_W-1:0]    command,
  input  logic [smrb_pkg::REG_W-1:0]    reg_index,
  input  logic [smrb_pkg::WORD_W-1:0]   write_data,
  input  logic [smrb_pkg::BYTE_W-1:0]   miso_byte,
  input  logic                          miso_first,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [smrb_pkg::WORD_W-1:0]   out_read_data,
  output logic [smrb_pkg::BYTE_W-1:0]   out_tx_byte,
  output logic                          out_last
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

  logic [smrb_pkg::CMD_W-1:0]  item_command;
  logic [smrb_pkg::REG_W-1:0]  item_reg;
  logic [smrb_pkg::WORD_W-1:0] item_data;
  logic [smrb_pkg::BYTE_W-1:0] item_byte;
  logic                        item_first;

  logic                        active;
  logic [smrb_pkg::WORD_W-1:0] clock_div;
  logic [smrb_pkg::WORD_W-1:0] data_len;
  logic [CW-1:0]               tx_count;
  logic [CW-1:0]               rx_count;
  logic [CW-1:0]               rx_read_pos;
  logic [AW-1:0]               drain_idx;

  logic                        is_read;
  logic                        is_write;
  logic                        is_miso;
  logic                        clear_req;
  logic                        start_req;
  logic [CW-1:0]               tx_base;
  logic [CW-1:0]               rx_base;
  logic                        rx_has;
  logic                        out_free;
  logic                        tx_last;
  logic                        out_load;
  logic [smrb_pkg::WORD_W-1:0] status_word;
  logic [smrb_pkg::WORD_W-1:0] read_value;

  logic                        tx_we;
  logic [AW-1:0]               tx_raddr;
  logic [smrb_pkg::BYTE_W-1:0] tx_rd_data;
  logic                        rx_we;
  logic [smrb_pkg::BYTE_W-1:0] rx_rd_data;

  assign is_read   = (item_command == smrb_pkg::CMD_READ);
  assign is_write  = (item_command == smrb_pkg::CMD_WRITE);
  assign is_miso   = (item_command == smrb_pkg::CMD_MISO);
  assign clear_req = ((item_data & smrb_pkg::CLEAR_MASK) != '0);
  assign start_req = ((item_data & smrb_pkg::STAT_ACTIVE) != '0);
  assign tx_base   = clear_req ? '0 : tx_count;
  assign rx_base   = item_first ? '0 : rx_count;
  assign rx_has    = (rx_read_pos < rx_count);
  assign out_free  = !out_valid || out_ready;
  assign tx_last   = ((CW'(drain_idx) + CW'(1)) == tx_count);
  assign out_load  = (cmd.exec && is_read) || cmd.emit;

  assign sts.is_read  = is_read;
  assign sts.starts   = is_write && (item_reg == smrb_pkg::REG_CONTROL) && start_req &&
                        !active && (tx_base != '0);
  assign sts.out_free = out_free;
  assign sts.tx_last  = tx_last;

  assign status_word = (active ? smrb_pkg::STAT_ACTIVE : '0) |
                       ((active && (tx_count != '0)) ? smrb_pkg::STAT_DONE : '0) |
                       (rx_has ? smrb_pkg::STAT_RXD : smrb_pkg::STAT_TXD);

  always_comb begin
    unique case (item_reg)
      smrb_pkg::REG_CONTROL: read_value = status_word;
      smrb_pkg::REG_FIFO:    read_value = rx_has ? {24'd0, rx_rd_data} : smrb_pkg::EMPTY_READ;
      smrb_pkg::REG_CLOCK:   read_value = clock_div;
      smrb_pkg::REG_LENGTH:  read_value = data_len;
      default:               read_value = '0;
    endcase
  end

  assign tx_we    = cmd.exec && is_write && (item_reg == smrb_pkg::REG_FIFO) &&
                    (tx_count < DEPTH_C);
  assign tx_raddr = cmd.emit ? (drain_idx + AW'(1)) : drain_idx;
  assign rx_we    = cmd.exec && is_miso && (rx_base < DEPTH_C);

  smrb_ram #(
    .WIDTH (smrb_pkg::BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_count[AW-1:0]),
    .wdata (item_data[smrb_pkg::BYTE_W-1:0]),
    .raddr (tx_raddr),
    .rdata (tx_rd_data)
  );

  smrb_ram #(
    .WIDTH (smrb_pkg::BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_base[AW-1:0]),
    .wdata (item_byte),
    .raddr (rx_read_pos[AW-1:0]),
    .rdata (rx_rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_command <= command;
      item_reg     <= reg_index;
      item_data    <= write_data;
      item_byte    <= miso_byte;
      item_first   <= miso_first;
    end
    if (out_load) begin
      if (cmd.emit) begin
        out_kind      <= smrb_pkg::KIND_TX;
        out_read_data <= '0;
        out_tx_byte   <= tx_rd_data;
        out_last      <= tx_last;
      end else begin
        out_kind      <= smrb_pkg::KIND_READ;
        out_read_data <= read_value;
        out_tx_byte   <= '0;
        out_last      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      active      <= 1'b0;
      clock_div   <= '0;
      data_len    <= '0;
      tx_count    <= '0;
      rx_count    <= '0;
      rx_read_pos <= '0;
      drain_idx   <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.exec) begin
        unique case (item_command)
          smrb_pkg::CMD_READ: begin
            if ((item_reg == smrb_pkg::REG_FIFO) && rx_has) begin
              rx_read_pos <= rx_read_pos + CW'(1);
            end
          end
          smrb_pkg::CMD_WRITE: begin
            unique case (item_reg)
              smrb_pkg::REG_CONTROL: begin
                if (clear_req) begin
                  tx_count    <= '0;
                  rx_count    <= '0;
                  rx_read_pos <= '0;
                end
                active <= start_req;
              end
              smrb_pkg::REG_FIFO: begin
                if (tx_count < DEPTH_C) begin
                  tx_count <= tx_count + CW'(1);
                end
              end
              smrb_pkg::REG_CLOCK:  clock_div <= item_data;
              smrb_pkg::REG_LENGTH: data_len  <= item_data;
              default: begin
              end
            endcase
          end
          smrb_pkg::CMD_MISO: begin
            if (item_first) begin
              rx_read_pos <= '0;
            end
            if (rx_base < DEPTH_C) begin
              rx_count <= rx_base + CW'(1);
            end else begin
              rx_count <= rx_base;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.emit) begin
        drain_idx <= tx_last ? '0 : (drain_idx + AW'(1));
      end
    end
  end

  `SMRB_ASSERT_ALWAYS(a_tx_count_bound, tx_count <= DEPTH_C)
  `SMRB_ASSERT_ALWAYS(a_rx_pos_bound, (rx_read_pos <= rx_count) && (rx_count <= DEPTH_C))
  `SMRB_ASSERT_IMPLY(a_emit_in_range, cmd.emit, (CW'(drain_idx) < tx_count) && out_free)
  `SMRB_ASSERT_NEXT(a_emit_loads, cmd.emit, out_valid && (out_kind == smrb_pkg::KIND_TX))

endmodule

### design/spi_master_register_bridge.sv
// Top level of the SPI master register bridge: controller, datapath and channel ports.
// Each request is first accepted into the item registers and then applied; a bus read result
// is loaded into the output register when it is applied. A control write that starts a
// transfer then sends one queued TX byte per cycle while the output is free, paced by the
// registered read port of the TX memory. A stalled response holds the controller; the next
// request is still taken while a finished result waits. Synchronous reset clears state,
// control registers and counters; the FIFO memories are not cleared and need no clearing pass.
module spi_master_register_bridge #(
  parameter int FIFO_DEPTH = smrb_pkg::DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  smrb_req_if.sink    req,
  smrb_rsp_if.source  rsp
);

  smrb_pkg::ctrl_cmd_t  cmd;
  smrb_pkg::dp_status_t sts;
  logic                 in_ready;

  assign req.ready = in_ready;

  smrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  smrb_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .command       (req.command),
    .reg_index     (req.reg_index),
    .write_data    (req.write_data),
    .miso_byte     (req.miso_byte),
    .miso_first    (req.miso_first),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .out_kind      (rsp.kind),
    .out_read_data (rsp.read_data),
    .out_tx_byte   (rsp.tx_byte),
    .out_last      (rsp.last)
  );

endmodule
